FILE: rtl/stri_pkg.sv
// ----------------------------------------------------------------------------
// stri_pkg
// Shared types and constants for the segment versus triangle intersection core.
// ----------------------------------------------------------------------------
package stri_pkg;

    localparam int COORD_BITS    = 21;
    localparam int FRACTION_BITS = 16;
    localparam int FIELD_BITS    = 63;
    localparam int FRAC_OUT_BITS = 17;

    typedef struct packed {
        logic [FIELD_BITS-1:0] vertex_a;
        logic [FIELD_BITS-1:0] vertex_b;
        logic [FIELD_BITS-1:0] vertex_c;
        logic [FIELD_BITS-1:0] plane_normal;
        logic [FIELD_BITS-1:0] seg_begin;
        logic [FIELD_BITS-1:0] seg_end;
    } in_item_t;

    typedef struct packed {
        logic                     hit;
        logic [FRAC_OUT_BITS-1:0] fraction_along;
        logic [FIELD_BITS-1:0]    crossing_point;
        logic                     crossing_side;
    } out_item_t;

endpackage

FILE: rtl/segment_triangle_intersect_core.sv
// ----------------------------------------------------------------------------
// segment_triangle_intersect_core
// Exact integer test of a directed segment against a triangle, fully pipelined.
// ----------------------------------------------------------------------------
// Each item passes through the registered stages A, B, C, D, the divider stages, P1, P2 and E1 to E4.
// Throughput: one item per cycle while the output is not stalled; the fraction divider is unrolled one quotient
// bit per stage, so no unit is shared between items.
// Each stage stalls only when the stage after it is full and stalled, so bubbles close up.
// Reset (rst_n, asynchronous, active low) clears all stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
module segment_triangle_intersect_core #(
    parameter int COORD_BITS    = stri_pkg::COORD_BITS,
    parameter int FRACTION_BITS = stri_pkg::FRACTION_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  stri_pkg::in_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output stri_pkg::out_item_t out_item
);

    localparam int CB  = COORD_BITS;
    localparam int FB  = FRACTION_BITS;
    localparam int DW  = CB + 1;          // coordinate difference
    localparam int PW  = CB + DW;         // normal times difference
    localparam int SW  = PW + 2;          // sum of three products
    localparam int WW  = PW + 1;          // cross product component
    localparam int HB  = DW / 2;          // low split of the point offset
    localparam int PHW = DW - HB;
    localparam int HPW = WW + PHW;
    localparam int LPW = WW + HB + 1;
    localparam int TW  = WW + DW + 3;
    localparam int QW  = FB + 1;
    localparam int MW  = QW + 1 + DW;
    localparam int FW  = stri_pkg::FIELD_BITS;
    localparam int OFW = stri_pkg::FRAC_OUT_BITS;

    localparam int ST_A   = 0;
    localparam int ST_B   = 1;
    localparam int ST_C   = 2;
    localparam int ST_D   = 3;
    localparam int ST_DIV = 4;
    localparam int ST_P1  = FB + 5;
    localparam int ST_P2  = FB + 6;
    localparam int ST_E1  = FB + 7;
    localparam int ST_E2  = FB + 8;
    localparam int ST_E3  = FB + 9;
    localparam int ST_E4  = FB + 10;
    localparam int NS     = FB + 11;

    typedef struct {
        logic signed [CB-1:0] n   [3];
        logic signed [CB-1:0] vtx [3][3];
        logic signed [CB-1:0] sb  [3];
        logic signed [DW-1:0] rs  [3];
        logic signed [DW-1:0] re  [3];
        logic signed [DW-1:0] d   [3];
        logic signed [DW-1:0] ed  [3][3];
    } a_t;

    typedef struct {
        logic signed [PW-1:0] ps  [3];
        logic signed [PW-1:0] pe  [3];
        logic signed [PW-1:0] m   [3][6];
        logic signed [CB-1:0] vtx [3][3];
        logic signed [CB-1:0] sb  [3];
        logic signed [DW-1:0] d   [3];
    } b_t;

    typedef struct {
        logic signed [WW-1:0] w   [3][3];
        logic signed [CB-1:0] vtx [3][3];
        logic signed [CB-1:0] sb  [3];
        logic signed [DW-1:0] d   [3];
        logic                 miss;
        logic                 side;
    } carry_t;

    typedef struct {
        carry_t               cr;
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] e;
    } c_t;

    typedef struct {
        carry_t        cr;
        logic [SW-1:0] num;
        logic [SW-1:0] den;
    } d_t;

    typedef struct {
        carry_t        cr;
        logic [SW:0]   rem;
        logic [SW-1:0] den;
        logic [QW-1:0] q;
    } div_t;

    typedef struct {
        carry_t               cr;
        logic [QW-1:0]        q;
        logic signed [MW-1:0] prod [3];
    } p1_t;

    typedef struct {
        carry_t               cr;
        logic [QW-1:0]        q;
        logic signed [CB-1:0] pt [3];
    } p2_t;

    typedef struct {
        logic signed [WW-1:0] w  [3][3];
        logic signed [DW-1:0] pv [3][3];
        logic [QW-1:0]        q;
        logic signed [CB-1:0] pt [3];
        logic                 miss;
        logic                 side;
    } e1_t;

    typedef struct {
        logic signed [HPW-1:0] hp [3][3];
        logic signed [LPW-1:0] lp [3][3];
        logic [QW-1:0]         q;
        logic signed [CB-1:0]  pt [3];
        logic                  miss;
        logic                  side;
    } e2_t;

    typedef struct {
        logic signed [HPW+1:0] hs [3];
        logic signed [LPW+1:0] ls [3];
        logic [QW-1:0]         q;
        logic signed [CB-1:0]  pt [3];
        logic                  miss;
        logic                  side;
    } e3_t;

    function automatic logic signed [CB-1:0] coord(input logic [FW-1:0] word, input int axis);
        coord = word[axis*CB +: CB];
    endfunction

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    a_t  a_reg,  a_next;
    b_t  b_reg,  b_next;
    c_t  c_reg,  c_next;
    d_t  d_reg,  d_next;
    div_t div_reg [FB+1];
    div_t div0_next;
    p1_t p1_reg, p1_next;
    p2_t p2_reg, p2_next;
    e1_t e1_reg, e1_next;
    e2_t e2_reg, e2_next;
    e3_t e3_reg, e3_next;
    stri_pkg::out_item_t out_reg, out_next;

    logic signed [CB-1:0] se_c [3];
    logic signed [SW:0]   sdiff;
    logic signed [TW-1:0] tot [3];

    // A stage may take a new item when it is empty or its item moves on.
    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[ST_A];
    assign out_valid = vld_reg[NS-1];
    assign out_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage A: unpack and form all coordinate differences.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            a_next.n[k]      = coord(in_item.plane_normal, k);
            a_next.vtx[0][k] = coord(in_item.vertex_a, k);
            a_next.vtx[1][k] = coord(in_item.vertex_b, k);
            a_next.vtx[2][k] = coord(in_item.vertex_c, k);
            a_next.sb[k]     = coord(in_item.seg_begin, k);
            se_c[k]          = coord(in_item.seg_end, k);
            a_next.rs[k]     = DW'(a_next.sb[k]) - DW'(a_next.vtx[0][k]);
            a_next.re[k]     = DW'(se_c[k]) - DW'(a_next.vtx[0][k]);
            a_next.d[k]      = DW'(se_c[k]) - DW'(a_next.sb[k]);
        end
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_next.ed[j][k] = DW'(a_next.vtx[(j == 2) ? 0 : j + 1][k])
                                - DW'(a_next.vtx[j][k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_A])
        begin
            a_reg <= a_next;
        end
    end

    // Stage B: plane products and the products of N x edge.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            b_next.ps[k] = a_reg.n[k] * a_reg.rs[k];
            b_next.pe[k] = a_reg.n[k] * a_reg.re[k];
        end
        for (int j = 0; j < 3; j++)
        begin
            b_next.m[j][0] = a_reg.n[1] * a_reg.ed[j][2];
            b_next.m[j][1] = a_reg.n[2] * a_reg.ed[j][1];
            b_next.m[j][2] = a_reg.n[2] * a_reg.ed[j][0];
            b_next.m[j][3] = a_reg.n[0] * a_reg.ed[j][2];
            b_next.m[j][4] = a_reg.n[0] * a_reg.ed[j][1];
            b_next.m[j][5] = a_reg.n[1] * a_reg.ed[j][0];
        end
        b_next.vtx = a_reg.vtx;
        b_next.sb  = a_reg.sb;
        b_next.d   = a_reg.d;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_B])
        begin
            b_reg <= b_next;
        end
    end

    // Stage C: plane distances s, e and the vectors w = N x edge.
    always_comb
    begin
        c_next.s = SW'(b_reg.ps[0]) + SW'(b_reg.ps[1]) + SW'(b_reg.ps[2]);
        c_next.e = SW'(b_reg.pe[0]) + SW'(b_reg.pe[1]) + SW'(b_reg.pe[2]);
        for (int j = 0; j < 3; j++)
        begin
            c_next.cr.w[j][0] = WW'(b_reg.m[j][0]) - WW'(b_reg.m[j][1]);
            c_next.cr.w[j][1] = WW'(b_reg.m[j][2]) - WW'(b_reg.m[j][3]);
            c_next.cr.w[j][2] = WW'(b_reg.m[j][4]) - WW'(b_reg.m[j][5]);
        end
        c_next.cr.vtx  = b_reg.vtx;
        c_next.cr.sb   = b_reg.sb;
        c_next.cr.d    = b_reg.d;
        c_next.cr.miss = 1'b0;
        c_next.cr.side = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_C])
        begin
            c_reg <= c_next;
        end
    end

    // Stage D: plane decisions and the magnitudes for the divider.
    always_comb
    begin
        d_next.cr      = c_reg.cr;
        d_next.cr.miss = (c_reg.s < 0 && c_reg.e < 0) || (c_reg.s > 0 && c_reg.e > 0)
                      || (c_reg.s == 0 && c_reg.e == 0);
        d_next.cr.side = (c_reg.s < 0) || (c_reg.s == 0 && c_reg.e > 0);
        sdiff          = (SW+1)'(c_reg.s) - (SW+1)'(c_reg.e);
        d_next.num     = SW'((c_reg.s < 0) ? -c_reg.s : c_reg.s);
        d_next.den     = SW'((sdiff < 0) ? -sdiff : sdiff);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_D])
        begin
            d_reg <= d_next;
        end
    end

    // Divider, first stage: the integer bit; for a non-miss item, set only when s - e equals s.
    always_comb
    begin
        div0_next.cr  = d_reg.cr;
        div0_next.den = d_reg.den;
        if (d_reg.num >= d_reg.den)
        begin
            div0_next.q   = QW'(1);
            div0_next.rem = (SW+1)'(d_reg.num - d_reg.den);
        end
        else
        begin
            div0_next.q   = '0;
            div0_next.rem = (SW+1)'(d_reg.num);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_DIV])
        begin
            div_reg[0] <= div0_next;
        end
    end

    // One restoring step per stage; for an item that is not a miss, the remainder stays below den.
    for (genvar g = 1; g <= FB; g++)
    begin : g_div
        div_t        nx;
        logic [SW:0] r;

        always_comb
        begin
            nx = div_reg[g-1];
            r  = div_reg[g-1].rem << 1;
            if (r >= (SW+1)'(div_reg[g-1].den))
            begin
                nx.rem = r - (SW+1)'(div_reg[g-1].den);
                nx.q   = {div_reg[g-1].q[QW-2:0], 1'b1};
            end
            else
            begin
                nx.rem = r;
                nx.q   = {div_reg[g-1].q[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_DIV+g])
            begin
                div_reg[g] <= nx;
            end
        end
    end

    // Stage P1: fraction times segment direction.
    always_comb
    begin
        p1_next.cr = div_reg[FB].cr;
        p1_next.q  = div_reg[FB].q;
        for (int k = 0; k < 3; k++)
        begin
            p1_next.prod[k] = $signed({1'b0, div_reg[FB].q}) * div_reg[FB].cr.d[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_P1])
        begin
            p1_reg <= p1_next;
        end
    end

    // Stage P2: crossing point; the arithmetic shift floors the scaled offset.
    always_comb
    begin
        p2_next.cr = p1_reg.cr;
        p2_next.q  = p1_reg.q;
        for (int k = 0; k < 3; k++)
        begin
            p2_next.pt[k] = CB'(MW'(p1_reg.cr.sb[k]) + (p1_reg.prod[k] >>> FB));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_P2])
        begin
            p2_reg <= p2_next;
        end
    end

    // Stage E1: point relative to the first vertex of each edge.
    always_comb
    begin
        e1_next.w    = p2_reg.cr.w;
        e1_next.q    = p2_reg.q;
        e1_next.pt   = p2_reg.pt;
        e1_next.miss = p2_reg.cr.miss;
        e1_next.side = p2_reg.cr.side;
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_next.pv[j][k] = DW'(p2_reg.pt[k]) - DW'(p2_reg.cr.vtx[j][k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_E1])
        begin
            e1_reg <= e1_next;
        end
    end

    // Stage E2: w . pv as high and low partial products of the offset.
    always_comb
    begin
        e2_next.q    = e1_reg.q;
        e2_next.pt   = e1_reg.pt;
        e2_next.miss = e1_reg.miss;
        e2_next.side = e1_reg.side;
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e2_next.hp[j][k] = e1_reg.w[j][k] * $signed(e1_reg.pv[j][k][DW-1:HB]);
                e2_next.lp[j][k] = e1_reg.w[j][k] * $signed({1'b0, e1_reg.pv[j][k][HB-1:0]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_E2])
        begin
            e2_reg <= e2_next;
        end
    end

    // Stage E3: sum the partial products per edge.
    always_comb
    begin
        e3_next.q    = e2_reg.q;
        e3_next.pt   = e2_reg.pt;
        e3_next.miss = e2_reg.miss;
        e3_next.side = e2_reg.side;
        for (int j = 0; j < 3; j++)
        begin
            e3_next.hs[j] = (HPW+2)'(e2_reg.hp[j][0]) + (HPW+2)'(e2_reg.hp[j][1])
                          + (HPW+2)'(e2_reg.hp[j][2]);
            e3_next.ls[j] = (LPW+2)'(e2_reg.lp[j][0]) + (LPW+2)'(e2_reg.lp[j][1])
                          + (LPW+2)'(e2_reg.lp[j][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_E3])
        begin
            e3_reg <= e3_next;
        end
    end

    // Stage E4: exact edge signs and the result item.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            tot[j] = (TW'(e3_reg.hs[j]) <<< HB) + TW'(e3_reg.ls[j]);
        end
        out_next     = '0;
        out_next.hit = !e3_reg.miss && !tot[0][TW-1] && !tot[1][TW-1] && !tot[2][TW-1];
        if (out_next.hit)
        begin
            out_next.fraction_along = OFW'(e3_reg.q);
            out_next.crossing_side  = e3_reg.side;
            for (int k = 0; k < 3; k++)
            begin
                out_next.crossing_point[k*CB +: CB] = e3_reg.pt[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_E4])
        begin
            out_reg <= out_next;
        end
    end

    ap_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_D] && !d_reg.cr.miss |-> d_reg.num <= d_reg.den)
        else $error("fraction numerator exceeds denominator");

    ap_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_DIV+FB] && !div_reg[FB].cr.miss
            |-> div_reg[FB].rem < (SW+1)'(div_reg[FB].den))
        else $error("divider remainder out of range");

    ap_frac_max: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_P1] && !p1_reg.cr.miss |-> p1_reg.q <= (QW'(1) << FB))
        else $error("fraction above one");

    ap_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.hit
            |-> out_item.fraction_along == '0 && out_item.crossing_point == '0
                && !out_item.crossing_side)
        else $error("miss item carries nonzero fields");

    ap_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_E3] && out_valid && !out_ready |=> vld_reg[ST_E3] && $stable(e3_reg.q))
        else $error("item lost behind a stalled output");

endmodule
